// ===== sv/oaat_pkg.sv =====
// ---------------------------------------------------------------------------
// oaat_pkg
// Shared types, constants and mixing functions for the 64-bit
// one-at-a-time hash unit.
// ---------------------------------------------------------------------------
package oaat_pkg;

   localparam int HASH_W          = 64;
   localparam int BYTE_W          = 8;
   localparam int QUEUE_DEPTH_DEF = 2;

   localparam logic [BYTE_W-1:0] FOLD_LIMIT = 8'h5A;
   localparam logic [BYTE_W-1:0] FOLD_BIT   = 8'h20;

   localparam int MIX_SHL  = 10;
   localparam int MIX_SHR  = 6;
   localparam int FIN_SHL1 = 3;
   localparam int FIN_SHR  = 11;
   localparam int FIN_SHL2 = 15;

   typedef struct packed {
      logic [BYTE_W-1:0] term;
      logic              has_byte;
      logic              last;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   function automatic logic [HASH_W-1:0] mix_byte(input logic [HASH_W-1:0] h,
                                                  input logic [BYTE_W-1:0] term);
      logic [HASH_W-1:0] s;
      s = h + {{(HASH_W-BYTE_W){term[BYTE_W-1]}}, term};
      s = s + (s << MIX_SHL);
      s = s ^ (s >> MIX_SHR);
      return s;
   endfunction

   function automatic logic [HASH_W-1:0] fin_first(input logic [HASH_W-1:0] h);
      logic [HASH_W-1:0] s;
      s = h + (h << FIN_SHL1);
      s = s ^ (s >> FIN_SHR);
      return s;
   endfunction

   function automatic logic [HASH_W-1:0] fin_second(input logic [HASH_W-1:0] h);
      return h + (h << FIN_SHL2);
   endfunction

endpackage

// ===== sv/oaat_front.sv =====
// ---------------------------------------------------------------------------
// oaat_front
// Request intake: applies case folding, drops requests that carry neither
// a byte nor an end mark, and pushes the rest into the queue.
// ---------------------------------------------------------------------------
module oaat_front (
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [oaat_pkg::BYTE_W-1:0]   req_ch,
   input  logic                          req_ch_valid,
   input  logic                          req_fold_case,
   input  logic                          req_last,
   input  oaat_pkg::qstat_type           q_stat,
   output logic                          push,
   output oaat_pkg::entry_type           push_entry
);

   logic fold;

   assign req_ready = !reset && !q_stat.full;

   always_comb begin
      fold = req_fold_case && (req_ch[oaat_pkg::BYTE_W-1] || (req_ch <= oaat_pkg::FOLD_LIMIT));
      push_entry.term     = fold ? (req_ch | oaat_pkg::FOLD_BIT) : req_ch;
      push_entry.has_byte = req_ch_valid;
      push_entry.last     = req_last;
      push = req_valid && req_ready && (req_ch_valid || req_last);
   end

endmodule

// ===== sv/oaat_queue.sv =====
// ---------------------------------------------------------------------------
// oaat_queue
// Small first-in first-out buffer between intake and hash engine.
// ---------------------------------------------------------------------------
module oaat_queue #(
   parameter int DEPTH = oaat_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  oaat_pkg::entry_type  push_entry,
   input  logic                 pop,
   output logic                 pop_valid,
   output oaat_pkg::entry_type  pop_entry,
   output oaat_pkg::qstat_type  q_stat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   oaat_pkg::entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic             do_pop;

   always_comb begin
      q_stat.full  = (count_ff == FULL_CNT);
      q_stat.empty = (count_ff == '0);
      pop_valid    = !q_stat.empty;
      pop_entry    = mem_ff[rd_ptr_ff];
      do_pop       = pop && pop_valid;
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      count_in     = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== sv/oaat_back.sv =====
// ---------------------------------------------------------------------------
// oaat_back
// Hash engine: mixes one byte a cycle into the running hash while not
// stalled, then runs the two-stage finalisation into the response register.
// ---------------------------------------------------------------------------
module oaat_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          pop_valid,
   input  oaat_pkg::entry_type           pop_entry,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [oaat_pkg::HASH_W-1:0]   rsp_hash
);

   logic [oaat_pkg::HASH_W-1:0] acc_ff,      acc_in;
   logic                        fin_valid_ff, fin_valid_in;
   logic [oaat_pkg::HASH_W-1:0] fin_hash_ff, fin_hash_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [oaat_pkg::HASH_W-1:0] rsp_hash_ff, rsp_hash_in;
   logic [oaat_pkg::HASH_W-1:0] mixed;
   logic                        out_take;
   logic                        fin_take;

   always_comb begin
      out_take = !rsp_valid_ff || rsp_ready;
      fin_take = !fin_valid_ff || out_take;
      pop      = pop_valid && fin_take;
      mixed    = pop_entry.has_byte ? oaat_pkg::mix_byte(acc_ff, pop_entry.term) : acc_ff;

      acc_in = acc_ff;
      if (pop) begin
         acc_in = pop_entry.last ? '0 : mixed;
      end

      fin_valid_in = fin_valid_ff;
      fin_hash_in  = fin_hash_ff;
      if (pop && pop_entry.last) begin
         fin_valid_in = 1'b1;
         fin_hash_in  = oaat_pkg::fin_first(mixed);
      end else if (out_take) begin
         fin_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_hash_in  = rsp_hash_ff;
      if (out_take) begin
         rsp_valid_in = fin_valid_ff;
         rsp_hash_in  = oaat_pkg::fin_second(fin_hash_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         fin_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         fin_valid_ff <= fin_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fin_hash_ff <= fin_hash_in;
      rsp_hash_ff <= rsp_hash_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hash  = rsp_hash_ff;

endmodule

// ===== sv/one_at_a_time_hash_64_unit.sv =====
// ---------------------------------------------------------------------------
// one_at_a_time_hash_64_unit
// 64-bit one-at-a-time string hash, one byte per request.
// ---------------------------------------------------------------------------
// Requests arrive on req_ with valid/ready: one byte (req_ch, taken as a
// signed char), req_ch_valid to say whether the byte counts, req_fold_case
// to set bit 5 on bytes up to 0x5A, and req_last to close the string.
// A request with req_last produces exactly one response on rsp_ (valid/
// ready) carrying rsp_hash; other requests produce nothing.
// Throughput is one request per cycle while the output is not stalled: the
// engine mixes one byte a cycle into its running hash. A closing request
// passes through the queue, mix and first finalisation stage, and second
// finalisation stage into the output register before its response shows.
// A queue of QUEUE_DEPTH entries sits between intake and engine. While a
// response waits with rsp_ready low the output register holds, the engine
// stops once its finalisation stage is full, and req_ready drops when the queue fills.
// Synchronous reset empties the queue, clears the running hash to zero and
// drops rsp_valid; req_ready is low during reset.
// ---------------------------------------------------------------------------
module one_at_a_time_hash_64_unit #(
   parameter int QUEUE_DEPTH = oaat_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [oaat_pkg::BYTE_W-1:0]   req_ch,
   input  logic                          req_ch_valid,
   input  logic                          req_fold_case,
   input  logic                          req_last,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [oaat_pkg::HASH_W-1:0]   rsp_hash
);

   oaat_pkg::qstat_type q_stat;
   oaat_pkg::entry_type push_entry;
   oaat_pkg::entry_type pop_entry;
   logic                push;
   logic                pop;
   logic                pop_valid;

   oaat_front u_front (
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_ch        (req_ch),
      .req_ch_valid  (req_ch_valid),
      .req_fold_case (req_fold_case),
      .req_last      (req_last),
      .q_stat        (q_stat),
      .push          (push),
      .push_entry    (push_entry)
   );

   oaat_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .q_stat     (q_stat)
   );

   oaat_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_entry (pop_entry),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_hash  (rsp_hash)
   );

   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      !(q_stat.full && q_stat.empty))
      else $error("queue reports full and empty together");

   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      push |=> !q_stat.empty)
      else $error("pushed request missing from queue");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!rsp_valid && q_stat.empty))
      else $error("state not cleared by reset");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_stat.full |-> !push)
      else $error("push into full queue");

endmodule
